// ===== rtl/text_console_writer_macros.svh =====
// Assertion macros for the text console writer checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// No dependencies; used by the controller, datapath and top level.
package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_LINES   = 25;

    // Operation codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W = 1;
    localparam logic [0:0] REG_FG    = 1'b0;
    localparam logic [0:0] REG_BG    = 1'b1;

    localparam logic [3:0] FG_RESET = 4'd14;
    localparam logic [3:0] BG_RESET = 4'd0;

    // Character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Screen memory sweep kinds
    typedef enum logic [1:0] {
        SW_ZERO,
        SW_COPY,
        SW_BLANK
    } sweep_t;

    // Controller to datapath
    typedef struct packed {
        logic   load_item;
        logic   put_exec;
        logic   home;
        logic   rd_issue;
        logic   sweep_start;
        sweep_t start_mode;
        logic   sweep_run;
        sweep_t run_mode;
        logic   out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       put_scroll;
        logic       sweep_last;
        logic       out_free;
    } stat_t;

endpackage

// ===== rtl/tcw_ctrl.sv =====
// Sequencing state machine for the text console writer.
// Depends on tcw_pkg for command and status types.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_EXEC  = 7'b0000100,
        ST_CLEAR = 7'b0001000,
        ST_COPY  = 7'b0010000,
        ST_BLANK = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a word only when idle
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.start_mode  = SW_ZERO;
        cmd.run_mode    = SW_ZERO;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_run = 1'b1;
                cmd.run_mode  = SW_ZERO;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.op == OP_PUT)
                begin
                    cmd.put_exec = 1'b1;
                    if (stat.put_scroll)
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.start_mode  = SW_COPY;
                        state_next      = ST_COPY;
                    end
                    else if (stat.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (stat.op == OP_CLEAR)
                begin
                    cmd.home        = 1'b1;
                    cmd.sweep_start = 1'b1;
                    cmd.start_mode  = SW_ZERO;
                    state_next      = ST_CLEAR;
                end
                else if (stat.op == OP_READ)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (stat.out_free)
                begin
                    // Unused opcode: report the cursor only
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                cmd.sweep_run = 1'b1;
                cmd.run_mode  = SW_ZERO;
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COPY:
            begin
                cmd.sweep_run = 1'b1;
                cmd.run_mode  = SW_COPY;
                if (stat.sweep_last)
                begin
                    cmd.sweep_start = 1'b1;
                    cmd.start_mode  = SW_BLANK;
                    state_next      = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                cmd.sweep_run = 1'b1;
                cmd.run_mode  = SW_BLANK;
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/tcw_dpath.sv =====
// Datapath of the text console writer: screen memory, cursor, colors,
// sweep pointer and result register. Depends on tcw_pkg.
module tcw_dpath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int LINES   = DEF_LINES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic [1:0]           opcode,
    input  logic [7:0]           char_code,
    input  logic [6:0]           cell_col,
    input  logic [4:0]           cell_row,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [3:0]           cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [6:0]           cursor_col,
    output logic [4:0]           cursor_row,
    output logic                 did_scroll,
    output logic [7:0]           cell_char,
    output logic [7:0]           cell_attr
);

    localparam int CELLS = COLUMNS * LINES;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(LINES);

    localparam logic [AW-1:0]    PTR_LAST    = AW'(CELLS - 1);
    localparam logic [AW-1:0]    COPY_START  = AW'(COLUMNS);
    localparam logic [AW-1:0]    BLANK_START = AW'((LINES - 1) * COLUMNS);
    localparam logic [AW-1:0]    ROW_STRIDE  = AW'(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(LINES - 1);

    // Screen memory
    logic [15:0] mem [CELLS];
    logic [15:0] rd_data_reg;

    // Item, cursor and color registers
    logic [1:0]       op_reg;
    logic [7:0]       ch_reg;
    logic [6:0]       rc_reg;
    logic [4:0]       rr_reg;
    logic [COL_W-1:0] cur_col_reg;
    logic [ROW_W-1:0] cur_row_reg;
    logic [3:0]       fg_reg;
    logic [3:0]       bg_reg;
    logic             scroll_reg;

    // Sweep pointer and delayed write stage
    logic [AW-1:0] ptr_reg;
    logic          wr_pend_reg;
    logic [AW-1:0] wr_addr_reg;
    logic          wr_blank_reg;

    // Result register
    logic       out_valid_reg;
    logic [6:0] out_col_reg;
    logic [4:0] out_row_reg;
    logic       out_scroll_reg;
    logic [7:0] out_char_reg;
    logic [7:0] out_attr_reg;

    logic             is_nl;
    logic             col_last;
    logic             row_last;
    logic             line_feed;
    logic             put_scroll;
    logic [COL_W-1:0] put_col;
    logic [ROW_W-1:0] put_row;
    logic [31:0]      put_lin;
    logic [31:0]      rd_lin;
    logic             rd_in_range;
    logic [AW-1:0]    rd_item_addr;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [15:0]      mem_wd;
    logic             mem_re;
    logic [AW-1:0]    mem_ra;
    logic [COL_W-1:0] col_after;
    logic [ROW_W-1:0] row_after;
    logic [31:0]      col_after_w;
    logic [31:0]      row_after_w;
    logic             rd_hit;

    // Cursor advance for a put
    assign is_nl      = (ch_reg == CH_NL) || (ch_reg == CH_CR);
    assign col_last   = (cur_col_reg == COL_LAST);
    assign row_last   = (cur_row_reg == ROW_LAST);
    assign line_feed  = is_nl || col_last;
    assign put_scroll = line_feed && row_last;
    assign put_col    = line_feed ? '0 : cur_col_reg + COL_W'(1);
    assign put_row    = (line_feed && !row_last) ? cur_row_reg + ROW_W'(1) : cur_row_reg;

    // Cell addresses
    assign put_lin      = 32'(cur_row_reg) * 32'(COLUMNS) + 32'(cur_col_reg);
    assign rd_lin       = 32'(rr_reg) * 32'(COLUMNS) + 32'(rc_reg);
    assign rd_in_range  = (32'(rc_reg) < 32'(COLUMNS)) && (32'(rr_reg) < 32'(LINES));
    assign rd_item_addr = rd_in_range ? rd_lin[AW-1:0] : '0;

    // Pick the single memory write
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        priority if (wr_pend_reg)
        begin
            mem_we = 1'b1;
            mem_wa = wr_addr_reg;
            mem_wd = wr_blank_reg ? {rd_data_reg[15:8], CH_SPACE} : rd_data_reg;
        end
        else if (cmd.sweep_run && (cmd.run_mode == SW_ZERO))
        begin
            mem_we = 1'b1;
            mem_wa = ptr_reg;
        end
        else if (cmd.put_exec && !is_nl)
        begin
            mem_we = 1'b1;
            mem_wa = put_lin[AW-1:0];
            mem_wd = {bg_reg, fg_reg, ch_reg};
        end
        else
        begin
            // Leave the memory untouched
            mem_we = 1'b0;
        end
    end

    // Read for a cell fetch or a copy/blank sweep
    assign mem_re = cmd.rd_issue || (cmd.sweep_run && (cmd.run_mode != SW_ZERO));
    assign mem_ra = cmd.rd_issue ? rd_item_addr : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // Hold the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg <= opcode;
            ch_reg <= char_code;
            rc_reg <= cell_col;
            rr_reg <= cell_row;
        end
    end

    // Delayed write address for sweeps
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_run)
        begin
            wr_addr_reg  <= (cmd.run_mode == SW_COPY) ? ptr_reg - ROW_STRIDE : ptr_reg;
            wr_blank_reg <= (cmd.run_mode == SW_BLANK);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            fg_reg      <= FG_RESET;
            bg_reg      <= BG_RESET;
            scroll_reg  <= 1'b0;
            ptr_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            // Advance or home the cursor
            if (cmd.home)
            begin
                cur_col_reg <= '0;
                cur_row_reg <= '0;
            end
            else if (cmd.put_exec)
            begin
                cur_col_reg <= put_col;
                cur_row_reg <= put_row;
            end

            // Track whether this word scrolled
            if (cmd.load_item)
            begin
                scroll_reg <= 1'b0;
            end
            else if (cmd.put_exec)
            begin
                scroll_reg <= put_scroll;
            end

            // Color registers
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FG:  fg_reg <= cfg_data;
                    REG_BG:  bg_reg <= cfg_data;
                    default: ;
                endcase
            end

            // Load or step the sweep pointer
            if (cmd.sweep_start)
            begin
                unique case (cmd.start_mode)
                    SW_COPY:  ptr_reg <= COPY_START;
                    SW_BLANK: ptr_reg <= BLANK_START;
                    default:  ptr_reg <= '0;
                endcase
            end
            else if (cmd.sweep_run)
            begin
                ptr_reg <= ptr_reg + AW'(1);
            end

            wr_pend_reg <= cmd.sweep_run && (cmd.run_mode != SW_ZERO);
        end
    end

    // Result fields
    assign col_after   = cmd.put_exec ? put_col : cur_col_reg;
    assign row_after   = cmd.put_exec ? put_row : cur_row_reg;
    assign col_after_w = 32'(col_after);
    assign row_after_w = 32'(row_after);
    assign rd_hit      = (op_reg == OP_READ) && rd_in_range;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_col_reg    <= col_after_w[6:0];
            out_row_reg    <= row_after_w[4:0];
            out_scroll_reg <= cmd.put_exec ? put_scroll : scroll_reg;
            out_char_reg   <= rd_hit ? rd_data_reg[7:0] : 8'd0;
            out_attr_reg   <= rd_hit ? rd_data_reg[15:8] : 8'd0;
        end
    end

    // Result valid: set on load, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Status to the controller
    assign stat.op         = op_reg;
    assign stat.put_scroll = put_scroll;
    assign stat.sweep_last = (ptr_reg == PTR_LAST);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign cursor_col = out_col_reg;
    assign cursor_row = out_row_reg;
    assign did_scroll = out_scroll_reg;
    assign cell_char  = out_char_reg;
    assign cell_attr  = out_attr_reg;

endmodule

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_dpath.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    opcode, char_code, cell_col, cell_row
//   out      out_valid / out_stall  cursor_col, cursor_row, did_scroll,
//                                   cell_char, cell_attr
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A put without scroll and the unused opcode load their result in EXEC when
// the output is free; a read goes on through DONE (registered screen memory
// read). Clear runs one zeroing pass, and a put that scrolls a copy pass then
// a blank pass, over the single-write-port screen memory. After reset a
// clearing pass zeroes the screen while in_stall stays high; config writes
// are taken throughout. A new word is accepted while a result still waits on
// out_stall; that word then waits to finish until the result is taken.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int LINES   = DEF_LINES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic [7:0]           char_code,
    input  logic [6:0]           cell_col,
    input  logic [4:0]           cell_row,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [6:0]           cursor_col,
    output logic [4:0]           cursor_row,
    output logic                 did_scroll,
    output logic [7:0]           cell_char,
    output logic [7:0]           cell_attr,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [3:0]           cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // Color registers take a write every cycle
    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcw_dpath #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .opcode     (opcode),
        .char_code  (char_code),
        .cell_col   (cell_col),
        .cell_row   (cell_row),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .did_scroll (did_scroll),
        .cell_char  (cell_char),
        .cell_attr  (cell_attr)
    );

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level assertions for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_macros.svh.
`include "text_console_writer_macros.svh"

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int LINES   = DEF_LINES
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] cursor_col,
    input logic [4:0] cursor_row,
    input logic       did_scroll,
    input logic [7:0] cell_char,
    input logic [7:0] cell_attr
);

    // A stalled result word holds
    `TCW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cursor_col) && $stable(cursor_row) && $stable(did_scroll) && $stable(cell_char) && $stable(cell_attr), "stalled result changed")

    // An accepted word keeps the block busy in the cycle after
    `TCW_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "word accepted back to back")

    // Reported cursor stays on the screen
    `TCW_ASSERT_SAME(a_cursor_range, out_valid, (32'(cursor_col) < 32'(COLUMNS)) && (32'(cursor_row) < 32'(LINES)), "cursor off screen")

    // A scroll leaves the cursor at the start of the bottom row
    `TCW_ASSERT_SAME(a_scroll_home, out_valid && did_scroll, (cursor_col == 7'd0) && (cursor_row == 5'(LINES - 1)), "scroll left cursor misplaced")

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES)
) u_tcw_checker (.*);

// ===== dv/text_console_writer_tb.sv =====
// Testbench for the text console writer: directed, wrap/scroll, backpressure and random tests.
// Depends on tcw_pkg and text_console_writer; keeps its own shadow screen to predict each result.
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLS          = DEF_COLUMNS;
    localparam int ROWS          = DEF_LINES;
    localparam int CELLS         = COLS * ROWS;
    localparam int HOLD_CYCLES   = 300;
    localparam int STUCK_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [6:0] col;
        logic [4:0] row;
        logic       scrolled;
        logic [7:0] glyph;
        logic [7:0] attr;
    } console_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [1:0]           opcode    = OP_PUT;
    logic [7:0]           char_code = '0;
    logic [6:0]           cell_col  = '0;
    logic [4:0]           cell_row  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [6:0]           cursor_col;
    logic [4:0]           cursor_row;
    logic                 did_scroll;
    logic [7:0]           cell_char;
    logic [7:0]           cell_attr;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FG;
    logic [3:0]           cfg_data  = '0;

    // Shadow screen, cursor and colors
    logic [15:0]     shadow_cells [CELLS];
    int              shadow_col;
    int              shadow_row;
    logic [3:0]      attr_fg = FG_RESET;
    logic [3:0]      attr_bg = BG_RESET;
    console_result_t due_results [$];

    int fail_count  = 0;
    int stuck_count = 0;
    bit no_idle     = 1'b0;
    int hold_go     = 0;
    int hold_seen   = 0;
    int hold_left   = 0;

    text_console_writer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .char_code  (char_code),
        .cell_col   (cell_col),
        .cell_row   (cell_row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .did_scroll (did_scroll),
        .cell_char  (cell_char),
        .cell_attr  (cell_attr),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Move the shadow cursor to the next line, scrolling past the bottom
    function automatic logic advance_line();
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= ROWS)
        begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++)
                shadow_cells[i] = shadow_cells[i + COLS];
            // bottom row: blank characters, keep attributes
            for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
                shadow_cells[i] = {shadow_cells[i][15:8], CH_SPACE};
            shadow_row = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void wipe_screen();
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = '0;
        shadow_col = 0;
        shadow_row = 0;
    endfunction

    // Apply one accepted word to the shadow screen and return its result
    function automatic console_result_t apply_console_word(logic [1:0] op, logic [7:0] ch,
                                                           logic [6:0] col, logic [4:0] row);
        console_result_t res;
        res = '0;
        case (op)
            OP_PUT:
            begin
                if (ch == CH_NL || ch == CH_CR)
                    res.scrolled = advance_line();
                else
                begin
                    shadow_cells[shadow_row * COLS + shadow_col] = {attr_bg, attr_fg, ch};
                    shadow_col++;
                    if (shadow_col >= COLS)
                        res.scrolled = advance_line();
                end
            end
            OP_CLEAR:
                wipe_screen();
            OP_READ:
            begin
                if (col < COLS && row < ROWS)
                    {res.attr, res.glyph} = shadow_cells[row * COLS + col];
            end
            default:
                ;
        endcase
        res.col = shadow_col[6:0];
        res.row = shadow_row[4:0];
        return res;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Offer one word, optionally after a short gap, and predict it once taken
    task automatic issue_word(logic [1:0] op, logic [7:0] ch, logic [6:0] col, logic [4:0] row);
        if (!no_idle && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        char_code <= ch;
        cell_col  <= col;
        cell_row  <= row;
        do
            @(posedge clk);
        while (in_stall);
        due_results.push_back(apply_console_word(op, ch, col, row));
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FG)
            attr_fg = val;
        else
            attr_bg = val;
        @(posedge clk);
    endtask

    task automatic set_colors(logic [3:0] fg, logic [3:0] bg);
        drain();
        write_reg(REG_FG, fg);
        write_reg(REG_BG, bg);
    endtask

    function automatic logic [7:0] random_glyph();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(255));
        while (ch == CH_NL || ch == CH_CR);
        return ch;
    endfunction

    task automatic random_word();
        int         pick;
        logic [6:0] col;
        logic [4:0] row;
        pick = $urandom_range(99);
        col  = 7'($urandom_range(127));
        row  = 5'($urandom_range(31));
        if (pick < 2)
            issue_word(OP_CLEAR, 8'($urandom_range(255)), col, row);
        else if (pick < 5)
            issue_word(OP_UNUSED, 8'($urandom_range(255)), col, row);
        else if (pick < 35)
        begin
            // mostly in range, some out of range
            if ($urandom_range(99) < 85)
                issue_word(OP_READ, 8'($urandom_range(255)),
                           7'($urandom_range(COLS - 1)), 5'($urandom_range(ROWS - 1)));
            else
                issue_word(OP_READ, 8'($urandom_range(255)), col, row);
        end
        else if ($urandom_range(99) < 30)
            issue_word(OP_PUT, ($urandom_range(1) ? CH_NL : CH_CR), col, row);
        else
            issue_word(OP_PUT, random_glyph(), col, row);
    endtask

    task automatic test_directed();
        issue_word(OP_READ, 8'h00, 7'd0, 5'd0);
        issue_word(OP_PUT, 8'h00, 7'd0, 5'd0);
        issue_word(OP_PUT, 8'hFF, 7'd127, 5'd31);
        issue_word(OP_PUT, 8'h41, 7'd0, 5'd0);
        issue_word(OP_READ, 8'h00, 7'd0, 5'd0);
        issue_word(OP_READ, 8'hFF, 7'd1, 5'd0);
        issue_word(OP_READ, 8'h00, 7'd2, 5'd0);
        issue_word(OP_PUT, CH_NL, 7'd0, 5'd0);
        issue_word(OP_PUT, CH_CR, 7'd0, 5'd0);
        issue_word(OP_PUT, 8'h7E, 7'd0, 5'd0);
        issue_word(OP_READ, 8'h00, 7'd0, 5'd2);
        issue_word(OP_READ, 8'h00, 7'd127, 5'd31);
        issue_word(OP_READ, 8'h00, 7'd80, 5'd0);
        issue_word(OP_READ, 8'h00, 7'd0, 5'd25);
        issue_word(OP_READ, 8'h00, 7'd79, 5'd24);
        issue_word(OP_UNUSED, 8'hFF, 7'd127, 5'd31);
        issue_word(OP_UNUSED, 8'h00, 7'd0, 5'd0);
        issue_word(OP_CLEAR, 8'hFF, 7'd127, 5'd31);
        issue_word(OP_READ, 8'h00, 7'd0, 5'd0);
    endtask

    // Wrap at the last column, then scroll by wrap and by newline
    task automatic test_wrap_and_scroll();
        set_colors(4'd0, 4'd15);
        issue_word(OP_CLEAR, 8'h00, 7'd0, 5'd0);
        repeat (COLS - 1) issue_word(OP_PUT, random_glyph(), 7'd0, 5'd0);
        issue_word(OP_READ, 8'h00, 7'd78, 5'd0);
        issue_word(OP_PUT, random_glyph(), 7'd0, 5'd0);
        issue_word(OP_READ, 8'h00, 7'd79, 5'd0);
        for (int i = 1; i < ROWS - 1; i++)
            issue_word(OP_PUT, (i % 2 == 0) ? CH_NL : CH_CR, 7'd0, 5'd0);
        repeat (COLS) issue_word(OP_PUT, random_glyph(), 7'd0, 5'd0);
        issue_word(OP_READ, 8'h00, 7'd79, 5'd23);
        issue_word(OP_READ, 8'h00, 7'd0, 5'd23);
        issue_word(OP_READ, 8'h00, 7'd0, 5'd24);
        issue_word(OP_READ, 8'h00, 7'd79, 5'd24);
        issue_word(OP_PUT, CH_NL, 7'd0, 5'd0);
        issue_word(OP_READ, 8'h00, 7'd0, 5'd24);
    endtask

    // Hold the result side off while words keep coming, so the input stalls
    task automatic test_backpressure();
        set_colors(4'd15, 4'd0);
        hold_go++;
        repeat (16) random_word();
    endtask

    task automatic test_random_phases();
        repeat (60) random_word();
        set_colors(4'd0, 4'd0);
        no_idle = 1'b1;
        repeat (60) random_word();
        no_idle = 1'b0;
        set_colors(4'd15, 4'd15);
        repeat (60) random_word();
        set_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
        repeat (60) random_word();
    endtask

    initial
    begin
        wipe_screen();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_wrap_and_scroll();
        test_backpressure();
        test_random_phases();
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Result side stall: long hold-off on request, else random (none while no_idle is set)
    always @(posedge clk)
    begin
        if (hold_seen != hold_go)
        begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < 13);
    end

    // Compare each taken result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        console_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("result word with no pending prediction");
                fail_count++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("cursor_col", int'(want.col), int'(cursor_col));
                check_field("cursor_row", int'(want.row), int'(cursor_row));
                check_field("did_scroll", int'(want.scrolled), int'(did_scroll));
                check_field("cell_char", int'(want.glyph), int'(cell_char));
                check_field("cell_attr", int'(want.attr), int'(cell_attr));
            end
        end
    end

    // End the run if nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stuck_count <= 0;
        else if (stuck_count >= STUCK_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            stuck_count <= stuck_count + 1;
    end

endmodule
